[sv/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and helpers for the integer to ASCII digit converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned SIZE_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned BCD_DIGS = 20;
  localparam int unsigned DREG_W   = BCD_DIGS * DIGIT_W;
  localparam int unsigned CNT_W    = 7;

  // conversion codes
  localparam logic [FUNC_W-1:0] FUNC_BIN = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_OCT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SDEC = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_UDEC = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_HEXL = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_HEXU = 3'd5;

  // size codes
  localparam logic [SIZE_W-1:0] SIZE_8  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_32 = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_64 = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_A_LO  = 8'h61;

  // digit slots per radix once loaded into the digit register
  localparam logic [CNT_W-1:0] SLOTS_BIN = 7'd64;
  localparam logic [CNT_W-1:0] SLOTS_OCT = 7'd22;
  localparam logic [CNT_W-1:0] SLOTS_HEX = 7'd16;
  localparam logic [CNT_W-1:0] SLOTS_DEC = 7'd20;
  localparam logic [CNT_W-1:0] DABBLE_STEPS = 7'd64;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               sign;
    logic [VALUE_W-1:0] mag;
  } item_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'b0, d};
    end else begin
      base = upper ? CHAR_A_UP : CHAR_A_LO;
      digit_char = base + {4'b0, d - 4'd10};
    end
  endfunction

endpackage

[sv/itoa_front.sv]
// ----------------------------------------------------------------------------
// itoa_front
// Accepts items, masks the operand to its size, takes the magnitude of
// negative 32- and 64-bit signed decimal values, drops unknown conversion codes.
// ----------------------------------------------------------------------------
module itoa_front import itoa_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [SIZE_W-1:0]  size_code_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output item_t              push_item_o
);

  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] masked;
  logic               sign_bit;
  logic               neg;
  logic               func_ok;

  always_comb begin
    case (size_code_i)
      SIZE_8: begin
        mask = {{(VALUE_W-8){1'b0}}, {8{1'b1}}};
        sign_bit = 1'b0;
      end
      SIZE_16: begin
        mask = {{(VALUE_W-16){1'b0}}, {16{1'b1}}};
        sign_bit = 1'b0;
      end
      SIZE_32: begin
        mask = {{(VALUE_W-32){1'b0}}, {32{1'b1}}};
        sign_bit = value_i[31];
      end
      default: begin
        mask = {VALUE_W{1'b1}};
        sign_bit = value_i[VALUE_W-1];
      end
    endcase
  end

  assign masked  = value_i & mask;
  assign func_ok = (func_i <= FUNC_HEXU);
  assign neg     = (func_i == FUNC_SDEC) && sign_bit;

  // the most negative value negates to itself, which is already its magnitude
  assign push_item_o.func = func_i;
  assign push_item_o.sign = neg;
  assign push_item_o.mag  = neg ? ((~masked + 64'd1) & mask) : masked;

  assign push_valid_o = in_valid_i && func_ok;
  assign in_ready_o   = push_ready_i;

endmodule

[sv/itoa_fifo.sv]
// ----------------------------------------------------------------------------
// itoa_fifo
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module itoa_fifo import itoa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[sv/itoa_back.sv]
// ----------------------------------------------------------------------------
// itoa_back
// Converts one item at a time: double dabble for decimal, then leading zero
// skip and one character per cycle into the output register when it is free.
// ----------------------------------------------------------------------------
module itoa_back import itoa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  item_t             pop_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] char_out_o,
  output logic              last_o,
  output logic              negative_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DABBLE = 5'b00010,
    S_SKIP   = 5'b00100,
    S_SIGN   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [FUNC_W-1:0]  func_q, func_d;
  logic               sign_q, sign_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [DREG_W-1:0]  dig_q, dig_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;
  logic               neg_q, neg_d;

  logic               slot_free;
  logic [DIGIT_W-1:0] top_digit;
  logic [DREG_W-1:0]  dig_shift;
  logic [DREG_W-1:0]  dig_adj;
  logic               is_dec;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == S_IDLE);
  assign is_dec      = (pop_item_i.func == FUNC_SDEC) || (pop_item_i.func == FUNC_UDEC);

  // top digit and one-digit shift depend on the radix
  always_comb begin
    case (func_q)
      FUNC_BIN: begin
        top_digit = {3'b000, dig_q[DREG_W-1]};
        dig_shift = {dig_q[DREG_W-2:0], 1'b0};
      end
      FUNC_OCT: begin
        top_digit = {1'b0, dig_q[DREG_W-1 -: 3]};
        dig_shift = {dig_q[DREG_W-4:0], 3'b000};
      end
      default: begin
        top_digit = dig_q[DREG_W-1 -: DIGIT_W];
        dig_shift = {dig_q[DREG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
    endcase
  end

  // add 3 to every bcd digit of 5 or more before each shift
  always_comb begin
    for (int i = 0; i < BCD_DIGS; i++) begin
      dig_adj[i*DIGIT_W +: DIGIT_W] = (dig_q[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                                    ? dig_q[i*DIGIT_W +: DIGIT_W] + 4'd3
                                    : dig_q[i*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    sign_d      = sign_q;
    bin_d       = bin_q;
    dig_d       = dig_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    neg_d       = neg_q;

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          func_d = pop_item_i.func;
          sign_d = pop_item_i.sign;
          if (is_dec) begin
            bin_d   = pop_item_i.mag;
            dig_d   = '0;
            cnt_d   = DABBLE_STEPS;
            state_d = S_DABBLE;
          end else begin
            case (pop_item_i.func)
              FUNC_BIN: begin
                dig_d = {pop_item_i.mag, {(DREG_W-VALUE_W){1'b0}}};
                cnt_d = SLOTS_BIN;
              end
              FUNC_OCT: begin
                // 22 octal digits span 66 bits
                dig_d = {2'b00, pop_item_i.mag, {(DREG_W-VALUE_W-2){1'b0}}};
                cnt_d = SLOTS_OCT;
              end
              default: begin
                dig_d = {pop_item_i.mag, {(DREG_W-VALUE_W){1'b0}}};
                cnt_d = SLOTS_HEX;
              end
            endcase
            state_d = S_SKIP;
          end
        end
      end
      S_DABBLE: begin
        dig_d = {dig_adj[DREG_W-2:0], bin_q[VALUE_W-1]};
        bin_d = {bin_q[VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          cnt_d   = SLOTS_DEC;
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros but keep at least one digit
        if (cnt_q != 7'd1 && top_digit == '0) begin
          dig_d = dig_shift;
          cnt_d = cnt_q - 7'd1;
        end else begin
          state_d = sign_q ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
          neg_d       = 1'b1;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_char(top_digit, func_q == FUNC_HEXU);
          last_d      = (cnt_q == 7'd1);
          neg_d       = sign_q;
          dig_d       = dig_shift;
          cnt_d       = cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    sign_q <= sign_d;
    bin_q  <= bin_d;
    dig_q  <= dig_d;
    cnt_q  <= cnt_d;
    char_q <= char_d;
    last_q <= last_d;
    neg_q  <= neg_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_o      = last_q;
  assign negative_o  = neg_q;

endmodule

[sv/integer_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Integer to ASCII conversion in binary, octal, decimal and hex, one
// character per output item, most significant digit first.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i/in_ready_o  | func_i, size_code_i, value_i
//  out     | out_valid_o/out_ready_i| char_out_o, last_o, negative_o
//
//  an item waits in a two-entry queue; the back part takes one at a time
//  decimal: double dabble, then zero skip and emit; binary, octal and hex:
//  zero skip and emit only; a '-' is emitted first for a negative value,
//  idle takes the next item from the queue; unknown codes are dropped
//  out_ready_i low holds the back part; the front stalls only on a full queue
//  reset is asynchronous, active low, and empties queue and output register
module integer_to_ascii_digits import itoa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [SIZE_W-1:0]  size_code_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  char_out_o,
  output logic               last_o,
  output logic               negative_o
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  itoa_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .size_code_i  (size_code_i),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  itoa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_out_o  (char_out_o),
    .last_o      (last_o),
    .negative_o  (negative_o)
  );

endmodule
